>>> design/virtio_mmio_register_block_assert.svh
// Assertion macros shared by the register block modules.
`ifndef VIRTIO_MMIO_REGISTER_BLOCK_ASSERT_SVH
`define VIRTIO_MMIO_REGISTER_BLOCK_ASSERT_SVH

// Check a same-cycle implication on the rising clock edge, idle in reset.
`define VMMIO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("register block assertion failed");

// Check an implication in the following cycle, idle in reset.
`define VMMIO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("register block assertion failed");

`endif

>>> design/vmmio_pkg.sv
// Shared types, offsets and constants of the virtio-mmio register block.
package vmmio_pkg;

  // Request kinds carried on the input channel
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_EVENT = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  // Register offsets within the device window
  localparam logic [11:0] OFF_MAGIC        = 12'h000;
  localparam logic [11:0] OFF_VERSION      = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID    = 12'h008;
  localparam logic [11:0] OFF_VENDOR_ID    = 12'h00c;
  localparam logic [11:0] OFF_DEV_FEAT     = 12'h010;
  localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h014;
  localparam logic [11:0] OFF_DRV_FEAT     = 12'h020;
  localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h024;
  localparam logic [11:0] OFF_QUEUE_SEL    = 12'h030;
  localparam logic [11:0] OFF_QUEUE_MAX    = 12'h034;
  localparam logic [11:0] OFF_QUEUE_NUM    = 12'h038;
  localparam logic [11:0] OFF_QUEUE_READY  = 12'h044;
  localparam logic [11:0] OFF_QUEUE_NOTIFY = 12'h050;
  localparam logic [11:0] OFF_IRQ_STATUS   = 12'h060;
  localparam logic [11:0] OFF_IRQ_ACK      = 12'h064;
  localparam logic [11:0] OFF_STATUS       = 12'h070;
  localparam logic [11:0] OFF_DESC_LO      = 12'h080;
  localparam logic [11:0] OFF_DESC_HI      = 12'h084;
  localparam logic [11:0] OFF_DRIVER_LO    = 12'h090;
  localparam logic [11:0] OFF_DRIVER_HI    = 12'h094;
  localparam logic [11:0] OFF_DEVICE_LO    = 12'h0a0;
  localparam logic [11:0] OFF_DEVICE_HI    = 12'h0a4;
  localparam logic [11:0] OFF_CONFIG_GEN   = 12'h0fc;

  // Identification values and limits
  localparam logic [31:0] MAGIC_VALUE      = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE    = 32'h0000_0002;
  localparam logic [31:0] DEVICE_ID_VALUE  = 32'h0000_0004;
  localparam logic [31:0] VENDOR_ID_VALUE  = 32'h554d_4551;
  localparam logic [31:0] MAX_RING_ENTRIES = 32'd128;
  localparam logic [63:0] OFFERED_RESET    = 64'h0000_0001_0000_0000;
  localparam int unsigned STATUS_FEATURES_OK_BIT = 3;

  // Fields of one bus access
  typedef struct packed {
    req_e        req_type;
    logic [11:0] offset;
    logic [31:0] write_data;
  } vmmio_req_t;

  // Fields of one result
  typedef struct packed {
    logic [31:0] read_data;
    logic        notify_valid;
    logic [31:0] notify_queue;
    logic        irq_raise;
    logic        device_reset;
  } vmmio_rsp_t;

endpackage

>>> design/vmmio_regfile.sv
// Register state, read decode and write handling of the virtio-mmio block.
module vmmio_regfile
  import vmmio_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  vmmio_req_t req_i,
  input  logic       cfg_we_i,
  input  logic [63:0] cfg_data_i,
  output vmmio_rsp_t rsp_o
);

  logic [63:0] offered_q, offered_d;
  logic [31:0] dev_sel_q, dev_sel_d;
  logic [31:0] drv_sel_q, drv_sel_d;
  logic [63:0] accepted_q, accepted_d;
  logic [31:0] sel_queue_q, sel_queue_d;
  logic [31:0] ring_entries_q, ring_entries_d;
  logic        ring_ready_q, ring_ready_d;
  logic [63:0] desc_base_q, desc_base_d;
  logic [63:0] driver_base_q, driver_base_d;
  logic [63:0] device_base_q, device_base_d;
  logic [31:0] irq_status_q, irq_status_d;
  logic [31:0] status_q, status_d;

  logic        q0;
  logic [31:0] rd_val;
  logic [31:0] wr_val;
  logic [31:0] status_or;
  logic        ring_cleared;

  assign q0     = (sel_queue_q == 32'd0);
  assign wr_val = req_i.write_data;

  // Decode register reads
  always_comb begin
    unique case (req_i.offset)
      OFF_MAGIC:        rd_val = MAGIC_VALUE;
      OFF_VERSION:      rd_val = VERSION_VALUE;
      OFF_DEVICE_ID:    rd_val = DEVICE_ID_VALUE;
      OFF_VENDOR_ID:    rd_val = VENDOR_ID_VALUE;
      OFF_DEV_FEAT: begin
        if (dev_sel_q == 32'd0) rd_val = offered_q[31:0];
        else if (dev_sel_q == 32'd1) rd_val = offered_q[63:32];
        else rd_val = 32'd0;
      end
      OFF_DEV_FEAT_SEL: rd_val = dev_sel_q;
      OFF_QUEUE_SEL:    rd_val = sel_queue_q;
      OFF_QUEUE_MAX:    rd_val = q0 ? MAX_RING_ENTRIES : 32'd0;
      OFF_QUEUE_NUM:    rd_val = ring_entries_q;
      OFF_QUEUE_READY:  rd_val = {31'd0, ring_ready_q};
      OFF_IRQ_STATUS:   rd_val = irq_status_q;
      OFF_STATUS:       rd_val = status_q;
      OFF_DESC_LO:      rd_val = desc_base_q[31:0];
      OFF_DESC_HI:      rd_val = desc_base_q[63:32];
      OFF_DRIVER_LO:    rd_val = driver_base_q[31:0];
      OFF_DRIVER_HI:    rd_val = driver_base_q[63:32];
      OFF_DEVICE_LO:    rd_val = device_base_q[31:0];
      OFF_DEVICE_HI:    rd_val = device_base_q[63:32];
      OFF_CONFIG_GEN:   rd_val = 32'd0;
      default:          rd_val = 32'd0;
    endcase
  end

  assign status_or = status_q | wr_val;

  // Compute next state and the result of the current access
  always_comb begin
    offered_d      = cfg_we_i ? cfg_data_i : offered_q;
    dev_sel_d      = dev_sel_q;
    drv_sel_d      = drv_sel_q;
    accepted_d     = accepted_q;
    sel_queue_d    = sel_queue_q;
    ring_entries_d = ring_entries_q;
    ring_ready_d   = ring_ready_q;
    desc_base_d    = desc_base_q;
    driver_base_d  = driver_base_q;
    device_base_d  = device_base_q;
    irq_status_d   = irq_status_q;
    status_d       = status_q;
    rsp_o          = '0;

    unique case (req_i.req_type)
      REQ_READ: rsp_o.read_data = rd_val;
      REQ_WRITE: begin
        unique case (req_i.offset)
          OFF_DEV_FEAT_SEL: dev_sel_d = wr_val;
          OFF_DRV_FEAT_SEL: drv_sel_d = wr_val;
          OFF_DRV_FEAT: begin
            if (drv_sel_q == 32'd0) accepted_d[31:0] = wr_val;
            else if (drv_sel_q == 32'd1) accepted_d[63:32] = wr_val;
          end
          OFF_QUEUE_SEL:   sel_queue_d = wr_val;
          OFF_QUEUE_NUM:   if (q0) ring_entries_d = wr_val;
          OFF_QUEUE_READY: if (q0) ring_ready_d = (wr_val != 32'd0);
          OFF_DESC_LO:     if (q0) desc_base_d[31:0] = wr_val;
          OFF_DESC_HI:     if (q0) desc_base_d[63:32] = wr_val;
          OFF_DRIVER_LO:   if (q0) driver_base_d[31:0] = wr_val;
          OFF_DRIVER_HI:   if (q0) driver_base_d[63:32] = wr_val;
          OFF_DEVICE_LO:   if (q0) device_base_d[31:0] = wr_val;
          OFF_DEVICE_HI:   if (q0) device_base_d[63:32] = wr_val;
          OFF_QUEUE_NOTIFY: begin
            rsp_o.notify_valid = 1'b1;
            rsp_o.notify_queue = wr_val;
          end
          OFF_IRQ_ACK: irq_status_d = irq_status_q & ~wr_val;
          OFF_STATUS: begin
            if (wr_val == 32'd0) begin
              // Drop status, interrupt and ring state back to their reset values
              status_d           = 32'd0;
              irq_status_d       = 32'd0;
              ring_ready_d       = 1'b0;
              ring_entries_d     = 32'd0;
              desc_base_d        = 64'd0;
              driver_base_d      = 64'd0;
              device_base_d      = 64'd0;
              rsp_o.device_reset = 1'b1;
            end else begin
              // Refuse FEATURES_OK if the driver took unoffered features
              status_d = status_or;
              if ((accepted_q & ~offered_q) != 64'd0) begin
                status_d[STATUS_FEATURES_OK_BIT] = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      REQ_EVENT: begin
        irq_status_d[0] = 1'b1;
        rsp_o.irq_raise = 1'b1;
      end
      REQ_NOP: ;
      default: ;
    endcase
  end

  // Hold configuration across accesses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offered_q <= OFFERED_RESET;
    end else begin
      offered_q <= offered_d;
    end
  end

  // Update device state once per processed access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q      <= '0;
      drv_sel_q      <= '0;
      accepted_q     <= '0;
      sel_queue_q    <= '0;
      ring_entries_q <= '0;
      ring_ready_q   <= 1'b0;
      desc_base_q    <= '0;
      driver_base_q  <= '0;
      device_base_q  <= '0;
      irq_status_q   <= '0;
      status_q       <= '0;
    end else if (step_en_i) begin
      dev_sel_q      <= dev_sel_d;
      drv_sel_q      <= drv_sel_d;
      accepted_q     <= accepted_d;
      sel_queue_q    <= sel_queue_d;
      ring_entries_q <= ring_entries_d;
      ring_ready_q   <= ring_ready_d;
      desc_base_q    <= desc_base_d;
      driver_base_q  <= driver_base_d;
      device_base_q  <= device_base_d;
      irq_status_q   <= irq_status_d;
      status_q       <= status_d;
    end
  end

  assign ring_cleared = !ring_ready_q && ring_entries_q == 32'd0 && status_q == 32'd0;

`include "virtio_mmio_register_block_assert.svh"

  `VMMIO_ASSERT_NEXT(a_reset_clears_ring, step_en_i && rsp_o.device_reset, ring_cleared)
  `VMMIO_ASSERT_NEXT(a_event_sets_irq, step_en_i && req_i.req_type == REQ_EVENT, irq_status_q[0])
  `VMMIO_ASSERT_NEXT(a_state_holds_idle, !step_en_i, $stable({accepted_q, status_q, irq_status_q}))

endmodule

>>> design/virtio_mmio_register_block.sv
// Top level of the virtio-mmio register block: input stage and result register.
//
// Register front end of a single-queue virtio-mmio entropy device.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one bus access
// per transfer: a register read, a register write, a completion event or a no-op.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
// result per access: read data, notify pulse, interrupt raise, device reset.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// 64-bit offered feature word; it is always ready. Write it only while idle; the block does not enforce this.
// An accepted access is captured in the input register, then decoded, and its
// result is loaded into the result register, where it stays valid until taken.
// Throughput: one access per cycle while the receiver does not stall; the decode
// and register update lie between the input register and the result register.
// When the receiver stalls, the result register holds; the input register
// fills and then in_stall_o rises until the result is taken.
// Reset clears both pipeline stages and puts every device register at its reset
// value, with only the version-1 feature offered.
module virtio_mmio_register_block
  import vmmio_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vmmio_req_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vmmio_rsp_t  out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  logic       s1_valid_q;
  vmmio_req_t s1_req_q;
  logic       out_valid_q;
  vmmio_rsp_t out_rsp_q;
  vmmio_rsp_t rsp;
  logic       out_free;
  logic       s1_advance;
  logic       in_xfer;
  logic [2:0] side_fx;
  logic       notify_clean;

  // Advance the input stage whenever the result register can take a value
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  vmmio_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (s1_advance),
    .req_i      (s1_req_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp)
  );

  // Hold the input stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (out_free || !s1_valid_q) begin
      s1_valid_q <= in_xfer;
    end
  end

  // Capture the accepted access
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q <= in_data_i;
    end
  end

  // Hold the result valid bit until the receiver takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_rsp_q;

  assign side_fx      = {out_rsp_q.notify_valid, out_rsp_q.irq_raise, out_rsp_q.device_reset};
  assign notify_clean = out_rsp_q.notify_valid || out_rsp_q.notify_queue == 32'd0;

`include "virtio_mmio_register_block_assert.svh"

  `VMMIO_ASSERT_NOW(a_one_side_effect, out_valid_q, $onehot0(side_fx))
  `VMMIO_ASSERT_NOW(a_notify_queue_zero, out_valid_q, notify_clean)
  `VMMIO_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q && out_valid_q)
  `VMMIO_ASSERT_NEXT(a_stage_moves, s1_valid_q && !out_valid_q, out_valid_q)

endmodule

>>> sim/virtio_mmio_register_block_tb.sv
// Self-checking testbench for the virtio-mmio register block with a shadow-register scoreboard.
`timescale 1ns / 100ps

module virtio_mmio_register_block_tb;
  import vmmio_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASE_COUNT  = 6;
  localparam int unsigned IDLE_PERCENT = 20;

  // Shadow copy of the register file; predicts one result per bus access
  class reg_shadow;
    logic [63:0] offered;
    logic [31:0] dev_sel;
    logic [31:0] drv_sel;
    logic [63:0] accepted;
    logic [31:0] sel_queue;
    logic [31:0] ring_entries;
    logic        ring_ready;
    logic [63:0] desc_base;
    logic [63:0] driver_base;
    logic [63:0] device_base;
    logic [31:0] irq_bits;
    logic [31:0] status_bits;
    vmmio_rsp_t  expected_results[$];
    int unsigned mismatches;

    function new();
      offered      = OFFERED_RESET;
      dev_sel      = '0;
      drv_sel      = '0;
      accepted     = '0;
      sel_queue    = '0;
      ring_entries = '0;
      ring_ready   = 1'b0;
      desc_base    = '0;
      driver_base  = '0;
      device_base  = '0;
      irq_bits     = '0;
      status_bits  = '0;
      mismatches   = 0;
    endfunction

    // Return the value a read at this offset sees
    function logic [31:0] read_reg(logic [11:0] off);
      logic [31:0] val;
      val = '0;
      case (off)
        OFF_MAGIC:        val = MAGIC_VALUE;
        OFF_VERSION:      val = VERSION_VALUE;
        OFF_DEVICE_ID:    val = DEVICE_ID_VALUE;
        OFF_VENDOR_ID:    val = VENDOR_ID_VALUE;
        OFF_DEV_FEAT: begin
          if (dev_sel == 32'd0) val = offered[31:0];
          else if (dev_sel == 32'd1) val = offered[63:32];
        end
        OFF_DEV_FEAT_SEL: val = dev_sel;
        OFF_QUEUE_SEL:    val = sel_queue;
        OFF_QUEUE_MAX:    val = (sel_queue == 32'd0) ? MAX_RING_ENTRIES : 32'd0;
        OFF_QUEUE_NUM:    val = ring_entries;
        OFF_QUEUE_READY:  val = {31'd0, ring_ready};
        OFF_IRQ_STATUS:   val = irq_bits;
        OFF_STATUS:       val = status_bits;
        OFF_DESC_LO:      val = desc_base[31:0];
        OFF_DESC_HI:      val = desc_base[63:32];
        OFF_DRIVER_LO:    val = driver_base[31:0];
        OFF_DRIVER_HI:    val = driver_base[63:32];
        OFF_DEVICE_LO:    val = device_base[31:0];
        OFF_DEVICE_HI:    val = device_base[63:32];
        default:          val = '0;
      endcase
      return val;
    endfunction

    // Update the shadow registers and build the result of one access
    function vmmio_rsp_t apply_access(vmmio_req_t acc);
      vmmio_rsp_t  rsp;
      logic        q0;
      logic [31:0] v;
      rsp = '0;
      q0  = (sel_queue == 32'd0);
      v   = acc.write_data;
      case (acc.req_type)
        REQ_READ: rsp.read_data = read_reg(acc.offset);
        REQ_WRITE: begin
          case (acc.offset)
            OFF_DEV_FEAT_SEL: dev_sel = v;
            OFF_DRV_FEAT_SEL: drv_sel = v;
            OFF_DRV_FEAT: begin
              if (drv_sel == 32'd0) accepted[31:0] = v;
              else if (drv_sel == 32'd1) accepted[63:32] = v;
            end
            OFF_QUEUE_SEL:   sel_queue = v;
            OFF_QUEUE_NUM:   if (q0) ring_entries = v;
            OFF_QUEUE_READY: if (q0) ring_ready = (v != 32'd0);
            OFF_DESC_LO:     if (q0) desc_base[31:0] = v;
            OFF_DESC_HI:     if (q0) desc_base[63:32] = v;
            OFF_DRIVER_LO:   if (q0) driver_base[31:0] = v;
            OFF_DRIVER_HI:   if (q0) driver_base[63:32] = v;
            OFF_DEVICE_LO:   if (q0) device_base[31:0] = v;
            OFF_DEVICE_HI:   if (q0) device_base[63:32] = v;
            OFF_QUEUE_NOTIFY: begin
              rsp.notify_valid = 1'b1;
              rsp.notify_queue = v;
            end
            OFF_IRQ_ACK: irq_bits = irq_bits & ~v;
            OFF_STATUS: begin
              if (v == 32'd0) begin
                // Device reset: drop status, interrupts and queue state
                status_bits  = '0;
                irq_bits     = '0;
                ring_ready   = 1'b0;
                ring_entries = '0;
                desc_base    = '0;
                driver_base  = '0;
                device_base  = '0;
                rsp.device_reset = 1'b1;
              end else begin
                // Refuse FEATURES_OK when the driver took unoffered features
                status_bits = status_bits | v;
                if (status_bits[STATUS_FEATURES_OK_BIT] && ((accepted & ~offered) != 64'd0))
                  status_bits[STATUS_FEATURES_OK_BIT] = 1'b0;
              end
            end
            default: ;
          endcase
        end
        REQ_EVENT: begin
          irq_bits[0]   = 1'b1;
          rsp.irq_raise = 1'b1;
        end
        default: ;
      endcase
      return rsp;
    endfunction

    function void note_access(vmmio_req_t acc);
      expected_results.insert(expected_results.size(), apply_access(acc));
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one result with the oldest expectation, field by field
    task check_result(vmmio_rsp_t got);
      vmmio_rsp_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.notify_valid !== want.notify_valid)
        report_mismatch($sformatf("notify_valid %b, want %b",
                                  got.notify_valid, want.notify_valid));
      if (got.notify_queue !== want.notify_queue)
        report_mismatch($sformatf("notify_queue %h, want %h",
                                  got.notify_queue, want.notify_queue));
      if (got.irq_raise !== want.irq_raise)
        report_mismatch($sformatf("irq_raise %b, want %b", got.irq_raise, want.irq_raise));
      if (got.device_reset !== want.device_reset)
        report_mismatch($sformatf("device_reset %b, want %b",
                                  got.device_reset, want.device_reset));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  vmmio_req_t  in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  vmmio_rsp_t  out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i  = '0;

  reg_shadow   shadow;
  logic [63:0] offered_now;
  bit          steady      = 1'b0;
  int unsigned hold_starts = 0;
  int unsigned hold_seen   = 0;
  int unsigned cycle_count = 0;

  logic [11:0] reg_offsets [23] = '{
    OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT, OFF_DEV_FEAT_SEL,
    OFF_DRV_FEAT, OFF_DRV_FEAT_SEL, OFF_QUEUE_SEL, OFF_QUEUE_MAX, OFF_QUEUE_NUM,
    OFF_QUEUE_READY, OFF_QUEUE_NOTIFY, OFF_IRQ_STATUS, OFF_IRQ_ACK, OFF_STATUS,
    OFF_DESC_LO, OFF_DESC_HI, OFF_DRIVER_LO, OFF_DRIVER_HI, OFF_DEVICE_LO, OFF_DEVICE_HI,
    OFF_CONFIG_GEN
  };

  virtio_mmio_register_block u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watch both channels; values read here are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) shadow.note_access(in_data_i);
      if (out_valid_o && !out_stall_i) shadow.check_result(out_data_o);
    end
  end

  // Stall the result side at random, or hold it off for a long stretch on request
  initial begin : result_receiver
    forever begin
      @(posedge clk_i);
      if (hold_starts != hold_seen) begin
        hold_seen = hold_starts;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (steady || !rst_ni) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Abort a run that hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one access, idling first at random, and hold it until the transfer
  task automatic send_access(input req_e kind, input logic [11:0] off,
                             input logic [31:0] data);
    vmmio_req_t acc;
    acc.req_type   = kind;
    acc.offset     = off;
    acc.write_data = data;
    if (!steady && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= acc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_offered(input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow.offered = val;
    offered_now    = val;
  endtask

  // Draw a mostly well-formed access, biased toward values that change state
  function automatic vmmio_req_t random_access();
    vmmio_req_t  acc;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) acc.req_type = REQ_READ;
    else if (pick < 85) acc.req_type = REQ_WRITE;
    else if (pick < 95) acc.req_type = REQ_EVENT;
    else acc.req_type = REQ_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      acc.offset = reg_offsets[$urandom_range(0, 22)];
    end else if (pick < 95) begin
      acc.offset = 12'($urandom_range(0, 4095));
    end else begin
      acc.offset      = reg_offsets[$urandom_range(0, 22)];
      acc.offset[1:0] = 2'($urandom_range(1, 3));
    end
    acc.write_data = $urandom;
    pick = $urandom_range(0, 99);
    case (acc.offset)
      OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL: if (pick < 75) acc.write_data = $urandom_range(0, 2);
      OFF_QUEUE_SEL: begin
        if (pick < 70) acc.write_data = '0;
        else if (pick < 85) acc.write_data = $urandom_range(1, 3);
      end
      OFF_QUEUE_READY: if (pick < 60) acc.write_data = $urandom_range(0, 1);
      OFF_IRQ_ACK:     if (pick < 50) acc.write_data = 32'h1;
      OFF_STATUS: begin
        if (pick < 20) acc.write_data = '0;
        else if (pick < 85) acc.write_data = 32'h1 << $urandom_range(0, 7);
      end
      OFF_DRV_FEAT: begin
        if (pick < 35) acc.write_data = $urandom & offered_now[31:0];
        else if (pick < 70) acc.write_data = $urandom & offered_now[63:32];
      end
      default: ;
    endcase
    return acc;
  endfunction

  initial begin : stimulus
    vmmio_req_t acc;
    shadow      = new();
    offered_now = OFFERED_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: feature windows, refused and granted FEATURES_OK, notify,
    // interrupt set and acknowledge, queue writes while another queue is
    // selected, unknown and unaligned offsets, no-op, device reset
    send_access(REQ_READ,  OFF_MAGIC,        32'h0);
    send_access(REQ_WRITE, OFF_DEV_FEAT_SEL, 32'h1);
    send_access(REQ_READ,  OFF_DEV_FEAT,     32'h0);
    send_access(REQ_WRITE, OFF_DEV_FEAT_SEL, 32'hffff_ffff);
    send_access(REQ_READ,  OFF_DEV_FEAT,     32'h0);
    send_access(REQ_WRITE, OFF_DRV_FEAT_SEL, 32'h1);
    send_access(REQ_WRITE, OFF_DRV_FEAT,     32'hffff_ffff);
    send_access(REQ_WRITE, OFF_STATUS,       32'h8);
    send_access(REQ_READ,  OFF_STATUS,       32'h0);
    send_access(REQ_WRITE, OFF_DRV_FEAT,     32'h1);
    send_access(REQ_WRITE, OFF_STATUS,       32'hffff_ffff);
    send_access(REQ_READ,  OFF_STATUS,       32'h0);
    send_access(REQ_WRITE, OFF_QUEUE_NOTIFY, 32'hffff_ffff);
    send_access(REQ_EVENT, 12'hfff,          32'hffff_ffff);
    send_access(REQ_READ,  OFF_IRQ_STATUS,   32'h0);
    send_access(REQ_WRITE, OFF_IRQ_ACK,      32'h1);
    send_access(REQ_WRITE, OFF_QUEUE_NUM,    32'hffff_ffff);
    send_access(REQ_WRITE, OFF_QUEUE_SEL,    32'h5);
    send_access(REQ_WRITE, OFF_DESC_HI,      32'hdead_beef);
    send_access(REQ_READ,  OFF_QUEUE_MAX,    32'h0);
    send_access(REQ_READ,  OFF_QUEUE_NUM,    32'h0);
    send_access(REQ_READ,  12'h0ff,          32'h0);
    send_access(REQ_NOP,   12'hfff,          32'hffff_ffff);
    send_access(REQ_WRITE, OFF_STATUS,       32'h0);
    send_access(REQ_WRITE, OFF_QUEUE_SEL,    32'h0);

    // Random phases, each under its own offered feature word
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        wait_for_results();
        case (ph)
          1:       write_offered(64'h0);
          2:       write_offered({64{1'b1}});
          3:       write_offered({$urandom, $urandom});
          4:       write_offered(OFFERED_RESET);
          default: write_offered({$urandom, $urandom} | OFFERED_RESET);
        endcase
      end
      steady = (ph == 2);
      if (ph == 1) hold_starts++;
      repeat (PHASE_ITEMS) begin
        acc = random_access();
        send_access(acc.req_type, acc.offset, acc.write_data);
      end
    end

    wait_for_results();
    repeat (5) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
